FILE: rtl/core/gmcb_pkg.sv
// Shared types, constants and GF(16) helpers for the MDS candidate builder/checker
package gmcb_pkg;

  localparam int NumCoef     = 36;
  localparam int NumSteps    = 8;
  localparam int FirstOpCoef = 28;
  localparam int StepOpCoef  = 29;
  localparam logic [4:0] RowOps    = 5'd12;
  localparam logic [4:0] ColOpsEnd = 5'd24;

  localparam logic [1:0] CfgPathOps = 2'd0;
  localparam logic [1:0] CfgValA    = 2'd1;
  localparam logic [1:0] CfgValB    = 2'd2;
  localparam logic [1:0] CfgValC    = 2'd3;

  typedef logic [3:0] gf_t;
  typedef gf_t [3:0][3:0] mat_t;

  typedef struct packed {
    logic [5:0] third_position;
    logic [5:0] second_position;
    logic [5:0] first_position;
  } in_beat_t;

  typedef struct packed {
    logic        is_mds;
    logic [63:0] matrix_out;
  } out_beat_t;

  // One pipeline slot: the candidate matrix and its coefficient vector.
  typedef struct packed {
    logic                  vld;
    gf_t [NumCoef-1:0]     coef;
    mat_t                  m;
  } slot_t;

  function automatic gf_t gf_mul(gf_t a, gf_t b);
    logic [3:0] r;
    logic [3:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ x;
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [1:0] pair_dst(logic [3:0] k);
    logic [1:0] d;
    case (k)
      4'd0, 4'd1, 4'd2:   d = 2'd0;
      4'd3, 4'd4, 4'd5:   d = 2'd1;
      4'd6, 4'd7, 4'd8:   d = 2'd2;
      default:            d = 2'd3;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] pair_src(logic [3:0] k);
    logic [1:0] s;
    case (k)
      4'd0:  s = 2'd1;
      4'd1:  s = 2'd2;
      4'd2:  s = 2'd3;
      4'd3:  s = 2'd0;
      4'd4:  s = 2'd2;
      4'd5:  s = 2'd3;
      4'd6:  s = 2'd0;
      4'd7:  s = 2'd1;
      4'd8:  s = 2'd3;
      4'd9:  s = 2'd0;
      4'd10: s = 2'd1;
      default: s = 2'd2;
    endcase
    return s;
  endfunction

  // Row/column combos for the 3x3 minors.
  function automatic logic [1:0] trip(logic [1:0] i, logic [1:0] k);
    logic [1:0] v;
    case (i)
      2'd0:    v = k;
      2'd1:    v = (k == 2'd2) ? 2'd3 : k;
      2'd2:    v = (k == 2'd0) ? 2'd0 : k + 2'd1;
      default: v = k + 2'd1;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/gmcb_cell.sv
// One step cell: optional row scaling, then at most one elementary row/column op
module gmcb_cell import gmcb_pkg::*; #(
  parameter int Step = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [4:0] op_code,
  input  slot_t      slot_in,
  output slot_t      slot_r
);

  mat_t  sc;
  mat_t  res;
  gf_t   alpha;
  logic [3:0] k;
  logic [1:0] d;
  logic [1:0] s;
  slot_t slot_nxt;

  always_comb begin
    alpha = slot_in.coef[(Step == 0) ? FirstOpCoef : StepOpCoef + Step - 1];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (Step == 0) sc[i][j] = slot_in.m[i][j];
        else sc[i][j] = gf_mul(slot_in.m[i][j], slot_in.coef[4 * (Step - 1) + i]);
      end
    end
    k = (op_code < RowOps) ? op_code[3:0] : 4'(op_code - RowOps);
    d = pair_dst(k);
    s = pair_src(k);
    res = sc;
    for (int i = 0; i < 4; i++) begin
      if (op_code < RowOps) res[d][i] = sc[d][i] ^ gf_mul(sc[s][i], alpha);
      else if (op_code < ColOpsEnd) res[i][d] = sc[i][d] ^ gf_mul(sc[i][s], alpha);
    end
    slot_nxt      = slot_in;
    slot_nxt.m    = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else if (adv) begin
      slot_r.vld <= slot_nxt.vld;
    end
    if (adv) begin
      slot_r.coef <= slot_nxt.coef;
      slot_r.m    <= slot_nxt.m;
    end
  end

endmodule

FILE: rtl/core/gmcb_check.sv
// MDS test stage: entries, 2x2 minors (stage 1) and 3x3 minors (stage 2)
module gmcb_check import gmcb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  slot_t slot_in,
  output logic  vld_r,
  output mat_t  m_r,
  output logic  ok_r
);

  logic  ok1_nxt;
  logic  ok2_nxt;
  logic  v1_r;
  mat_t  m1_r;
  logic  ok1_r;
  gf_t   a [3][3];
  gf_t   det;
  logic  [15:0] det_nz;

  always_comb begin
    ok1_nxt = 1'b1;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        if (slot_in.m[i][j] == '0) ok1_nxt = 1'b0;
    for (int r0 = 0; r0 < 4; r0++)
      for (int r1 = r0 + 1; r1 < 4; r1++)
        for (int c0 = 0; c0 < 4; c0++)
          for (int c1 = c0 + 1; c1 < 4; c1++)
            if ((gf_mul(slot_in.m[r0][c0], slot_in.m[r1][c1]) ^
                 gf_mul(slot_in.m[r1][c0], slot_in.m[r0][c1])) == '0) ok1_nxt = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        for (int kk = 0; kk < 3; kk++)
          for (int l = 0; l < 3; l++)
            a[kk][l] = m1_r[trip(2'(i), 2'(kk))][trip(2'(j), 2'(l))];
        det = gf_mul(a[0][0], gf_mul(a[1][1], a[2][2]) ^ gf_mul(a[1][2], a[2][1]))
            ^ gf_mul(a[0][1], gf_mul(a[1][0], a[2][2]) ^ gf_mul(a[1][2], a[2][0]))
            ^ gf_mul(a[0][2], gf_mul(a[1][1], a[2][0]) ^ gf_mul(a[1][0], a[2][1]));
        det_nz[4 * i + j] = (det != '0);
      end
    end
    ok2_nxt = ok1_r & (&det_nz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= slot_in.vld;
      vld_r <= v1_r;
    end
    if (adv) begin
      m1_r  <= slot_in.m;
      ok1_r <= ok1_nxt;
      m_r   <= m1_r;
      ok_r  <= ok2_nxt;
    end
  end

endmodule

FILE: rtl/core/gf16_mds_candidate_builder_checker.sv
// Top level: coefficient load, chain of eight op cells, MDS check, output skid
// Accepts one candidate per cycle while in_stall is low; a beat's result passes
// the load register, eight op cells, two check stages and the skid write
// before it is offered. Output stall fills a two-entry skid buffer; the
// chain freezes only while the skid is full and a beat waits at the check
// output, so the input stall comes from registers only.
module gf16_mds_candidate_builder_checker import gmcb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [39:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data
);

  logic [39:0] path_ops_r;
  gf_t         val_a_r, val_b_r, val_c_r;
  slot_t       load_nxt;
  slot_t       chain [NumSteps+1];
  logic        adv;
  logic        c_vld;
  mat_t        c_m;
  logic        c_ok;
  out_beat_t   sk_r [2];
  logic [1:0]  cnt_r;
  logic        rd_r;
  logic        wr_r;
  logic        acc_in;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_ops_r <= '0;
      val_a_r    <= 4'd2;
      val_b_r    <= 4'd2;
      val_c_r    <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_idx)
        CfgPathOps: path_ops_r <= cfg_wdata;
        CfgValA:    val_a_r    <= cfg_wdata[3:0];
        CfgValB:    val_b_r    <= cfg_wdata[3:0];
        CfgValC:    val_c_r    <= cfg_wdata[3:0];
        default:    path_ops_r <= path_ops_r;
      endcase
    end
  end

  // Chain advances unless the skid buffer could overflow.
  assign adv      = (cnt_r != 2'd2) || !c_vld;
  assign in_stall = !adv;
  assign acc_in   = in_valid && !in_stall;

  always_comb begin
    load_nxt.vld = in_valid;
    for (int i = 0; i < NumCoef; i++) begin
      load_nxt.coef[i] = 4'd1;
      if (in_data.first_position == 6'(i))  load_nxt.coef[i] = val_a_r;
      if (in_data.second_position == 6'(i)) load_nxt.coef[i] = val_b_r;
      if (in_data.third_position == 6'(i))  load_nxt.coef[i] = val_c_r;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        load_nxt.m[i][j] = (i == j) ? 4'd1 : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].vld <= 1'b0;
    end else if (adv) begin
      chain[0].vld <= load_nxt.vld;
    end
    if (adv) begin
      chain[0].coef <= load_nxt.coef;
      chain[0].m    <= load_nxt.m;
    end
  end

  for (genvar g = 0; g < NumSteps; g++) begin : g_cell
    gmcb_cell #(.Step(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .op_code (path_ops_r[5*g +: 5]),
      .slot_in (chain[g]),
      .slot_r  (chain[g+1])
    );
  end

  gmcb_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .slot_in (chain[NumSteps]),
    .vld_r   (c_vld),
    .m_r     (c_m),
    .ok_r    (c_ok)
  );

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (adv && c_vld) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'((adv && c_vld) ? 1 : 0) - 2'(pop ? 1 : 0);
    end
    if (adv && c_vld) begin
      sk_r[wr_r].matrix_out <= c_m;
      sk_r[wr_r].is_mds     <= c_ok;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = sk_r[rd_r];

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("skid overflow");
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && c_vld) |-> in_stall) else $error("accepted while full");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (rd_r == wr_r)) else $error("pointer mismatch");
  a_vld_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && adv) |=> chain[0].vld) else $error("lost beat");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench for the GF(16) MDS candidate builder and checker
`timescale 1ns / 100ps

module testbench;
  import gmcb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [39:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  logic [39:0] path_reg = '0;
  gf_t         val_a = 4'd2;
  gf_t         val_b = 4'd2;
  gf_t         val_c = 4'd2;
  out_beat_t   expected_q[$];
  int          fail_count = 0;
  bit          no_idle = 1'b0;

  gf16_mds_candidate_builder_checker dut (.*);

  always #2 clk = ~clk;

  function automatic gf_t fmul(gf_t a, gf_t b);
    gf_t r;
    gf_t x;
    r = '0;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r ^= x;
      x = x[3] ? ((x << 1) ^ 4'h3) : (x << 1);
    end
    return r;
  endfunction

  function automatic void elem_op(logic [4:0] code, gf_t alpha, ref gf_t m[4][4]);
    int dst_tab[12] = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3};
    int src_tab[12] = '{1, 2, 3, 0, 2, 3, 0, 1, 3, 0, 1, 2};
    int k;
    if (code < RowOps) begin
      k = int'(code);
      for (int i = 0; i < 4; i++) m[dst_tab[k]][i] ^= fmul(m[src_tab[k]][i], alpha);
    end else if (code < ColOpsEnd) begin
      k = int'(code - RowOps);
      for (int i = 0; i < 4; i++) m[i][dst_tab[k]] ^= fmul(m[i][src_tab[k]], alpha);
    end
  endfunction

  function automatic bit mds_ok(gf_t m[4][4]);
    int tr[4][3] = '{'{0, 1, 2}, '{0, 1, 3}, '{0, 2, 3}, '{1, 2, 3}};
    gf_t a[3][3];
    gf_t d;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        if (m[i][j] == 0) return 1'b0;
    for (int r0 = 0; r0 < 4; r0++)
      for (int r1 = r0 + 1; r1 < 4; r1++)
        for (int c0 = 0; c0 < 4; c0++)
          for (int c1 = c0 + 1; c1 < 4; c1++)
            if ((fmul(m[r0][c0], m[r1][c1]) ^ fmul(m[r1][c0], m[r0][c1])) == 0)
              return 1'b0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++)
          for (int l = 0; l < 3; l++) a[k][l] = m[tr[i][k]][tr[j][l]];
        d = fmul(a[0][0], fmul(a[1][1], a[2][2]) ^ fmul(a[1][2], a[2][1]))
          ^ fmul(a[0][1], fmul(a[1][0], a[2][2]) ^ fmul(a[1][2], a[2][0]))
          ^ fmul(a[0][2], fmul(a[1][1], a[2][0]) ^ fmul(a[1][0], a[2][1]));
        if (d == 0) return 1'b0;
      end
    return 1'b1;
  endfunction

  function automatic out_beat_t build_candidate(in_beat_t b);
    gf_t coef[NumCoef];
    gf_t m[4][4];
    out_beat_t r;
    foreach (coef[i]) coef[i] = 4'd1;
    if (b.first_position < NumCoef) coef[b.first_position] = val_a;
    if (b.second_position < NumCoef) coef[b.second_position] = val_b;
    if (b.third_position < NumCoef) coef[b.third_position] = val_c;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) m[i][j] = (i == j) ? 4'd1 : 4'd0;
    elem_op(path_reg[4:0], coef[FirstOpCoef], m);
    for (int s = 0; s < 7; s++) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) m[i][j] = fmul(m[i][j], coef[4 * s + i]);
      elem_op(path_reg[5 * (s + 1) +: 5], coef[StepOpCoef + s], m);
    end
    r.matrix_out = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) r.matrix_out[4 * (4 * i + j) +: 4] = m[i][j];
    r.is_mds = mds_ok(m);
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 37);
  endfunction

  task automatic send_beat(in_beat_t b);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(build_candidate(b));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgPathOps: path_reg = v;
      CfgValA:    val_a = v[3:0];
      CfgValB:    val_b = v[3:0];
      CfgValC:    val_c = v[3:0];
      default:    path_reg = path_reg;
    endcase
    @(negedge clk);
  endtask

  function automatic in_beat_t rand_beat(bit wide);
    in_beat_t b;
    b.first_position  = wide ? 6'($urandom_range(63)) : 6'($urandom_range(35));
    b.second_position = wide ? 6'($urandom_range(63)) : 6'($urandom_range(35));
    b.third_position  = wide ? 6'($urandom_range(63)) : 6'($urandom_range(35));
    return b;
  endfunction

  function automatic logic [39:0] rand_path(bit valid_only);
    logic [39:0] p;
    for (int s = 0; s < 8; s++)
      p[5 * s +: 5] = valid_only ? 5'($urandom_range(23)) : 5'($urandom_range(31));
    return p;
  endfunction

  task automatic test_directed();
    in_beat_t b;
    send_beat('{6'd0, 6'd0, 6'd0});
    send_beat('{6'd35, 6'd35, 6'd35});
    send_beat('{6'd63, 6'd36, 6'd63});
    send_beat('{6'd42, 6'd21, 6'd63});
    send_beat('{6'd28, 6'd29, 6'd35});
    drain();
    write_reg(CfgValA, 40'd15);
    write_reg(CfgValB, 40'd0);
    write_reg(CfgValC, 40'd9);
    write_reg(CfgPathOps, 40'hFF_FFFF_FFFF);
    send_beat('{6'd0, 6'd1, 6'd2});
    b = '{6'd5, 6'd5, 6'd5};
    send_beat(b);
    drain();
    for (int code = 0; code < 32; code += 4) begin
      write_reg(CfgPathOps, {8{code[4:0] + 5'(code % 3)}});
      send_beat('{6'd28, 6'd3, 6'd29});
      send_beat('{6'd0, 6'd17, 6'd34});
      drain();
    end
    write_reg(CfgPathOps, 40'h0);
    write_reg(CfgValA, 40'd0);
    write_reg(CfgValB, 40'd15);
    write_reg(CfgValC, 40'd1);
    send_beat('{6'd12, 6'd12, 6'd40});
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 15; ph++) begin
      write_reg(CfgPathOps, rand_path(ph % 4 != 3));
      write_reg(CfgValA, 40'($urandom_range(15)));
      write_reg(CfgValB, 40'($urandom_range(15)));
      write_reg(CfgValC, 40'($urandom_range(15)));
      no_idle = (ph == 7);
      for (int n = 0; n < 90; n++) send_beat(rand_beat($urandom_range(9) == 0));
      drain();
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk) out_stall <= idle_now();

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected beat %h", out_data);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.matrix_out !== e.matrix_out) begin
          $error("matrix_out exp %h got %h", e.matrix_out, out_data.matrix_out);
          fail_count++;
        end
        if (out_data.is_mds !== e.is_mds) begin
          $error("is_mds exp %b got %b", e.is_mds, out_data.is_mds);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    drain();
    if (fail_count == 0 && expected_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
